// ===== rtl/bmrc_pkg.sv =====
// Shared types and constants for the BGP message receive checker.
// No dependencies; every other file imports this package.
package bmrc_pkg;

    localparam int MaxMessageBytes = 4096;
    localparam int HeaderBytes     = 19;
    localparam int QueueDepth      = 2;

    // Multiply-by-reciprocal constant for an exact 16-bit divide by three
    localparam logic [16:0] DivThreeMul   = 17'd43691;
    localparam int          DivThreeShift = 17;

    typedef enum logic [2:0] {
        EV_OPEN   = 3'd0,
        EV_UPDATE = 3'd1,
        EV_NOTIFY = 3'd2,
        EV_KEEP   = 3'd3,
        EV_ERROR  = 3'd4
    } event_kind_t;

    typedef enum logic [7:0] {
        TYPE_OPEN   = 8'd1,
        TYPE_UPDATE = 8'd2,
        TYPE_NOTIFY = 8'd3,
        TYPE_KEEP   = 8'd4
    } msg_type_t;

    // Error codes and subcodes
    localparam logic [7:0] ERR_HEADER     = 8'd1;
    localparam logic [7:0] ERR_OPEN       = 8'd2;
    localparam logic [7:0] ERR_UPDATE     = 8'd3;
    localparam logic [7:0] SUB_MARKER     = 8'd1;
    localparam logic [7:0] SUB_LENGTH     = 8'd2;
    localparam logic [7:0] SUB_TYPE       = 8'd3;
    localparam logic [7:0] SUB_VERSION    = 8'd1;
    localparam logic [7:0] SUB_PEER_AS    = 8'd2;
    localparam logic [7:0] SUB_ROUTER_ID  = 8'd3;
    localparam logic [7:0] SUB_OPT_PARAM  = 8'd4;
    localparam logic [7:0] SUB_HOLD       = 8'd6;
    localparam logic [7:0] SUB_ATTR_LIST  = 8'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_PEER_AS   = 3'd0;
    localparam logic [2:0] CFG_ROUTER_ID = 3'd1;
    localparam logic [2:0] CFG_HOLD      = 3'd2;
    localparam logic [2:0] CFG_KEEPALIVE = 3'd3;

    // Classified message record passed from front to back
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  msg_type;
        logic [12:0] msg_length;
        logic [7:0]  code;
        logic [7:0]  subcode;
        logic [31:0] detail;
        logic [15:0] peer_as;
        logic [31:0] peer_id;
        logic [15:0] peer_hold;
    } msg_rec_t;

endpackage

// ===== rtl/bgp_message_receive_checker.sv =====
// BGP message receive checker: takes one stream byte per cycle with no
// bubbles while the two-entry record queue has room, and gives one result
// item on the last byte of each message, or on the type byte of a bad
// header (header check, OPEN validation, UPDATE section sizes,
// NOTIFICATION decode), via the record queue and output register. After
// an error or a NOTIFICATION all bytes are taken and dropped until reset.
// Depends on bmrc_pkg, bmrc_front, bmrc_queue and bmrc_back.
module bgp_message_receive_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  message_type,
    output logic [12:0] message_length,
    output logic [7:0]  code_value,
    output logic [7:0]  subcode_value,
    output logic [31:0] detail_data,
    output logic [15:0] peer_as_number,
    output logic [31:0] peer_router_id,
    output logic [15:0] agreed_hold,
    output logic [15:0] agreed_keepalive
);
    import bmrc_pkg::*;

    logic [15:0] peer_as_reg;
    logic [31:0] router_id_reg;
    logic [15:0] hold_reg;
    logic [15:0] keep_reg;

    logic     q_full, q_push, q_pop, q_avail;
    msg_rec_t q_in, q_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_as_reg   <= 16'd0;
            router_id_reg <= 32'd0;
            hold_reg      <= 16'd240;
            keep_reg      <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PEER_AS:   peer_as_reg   <= cfg_data[15:0];
                CFG_ROUTER_ID: router_id_reg <= cfg_data;
                CFG_HOLD:      hold_reg      <= cfg_data[15:0];
                CFG_KEEPALIVE: keep_reg      <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    bmrc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .expected_peer_as (peer_as_reg),
        .own_router_id    (router_id_reg),
        .queue_full       (q_full),
        .push             (q_push),
        .push_rec         (q_in)
    );

    bmrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_avail),
        .pop_rec   (q_out)
    );

    bmrc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .rec_avail          (q_avail),
        .rec                (q_out),
        .pop                (q_pop),
        .own_hold_time      (hold_reg),
        .own_keepalive_time (keep_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .event_kind         (event_kind),
        .message_type       (message_type),
        .message_length     (message_length),
        .code_value         (code_value),
        .subcode_value      (subcode_value),
        .detail_data        (detail_data),
        .peer_as_number     (peer_as_number),
        .peer_router_id     (peer_router_id),
        .agreed_hold        (agreed_hold),
        .agreed_keepalive   (agreed_keepalive)
    );

endmodule

// ===== rtl/bmrc_front.sv =====
// Front end: accepts stream bytes, captures header and body fields and
// classifies each finished message into a record. Depends on bmrc_pkg.
module bmrc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic [15:0]        expected_peer_as,
    input  logic [31:0]        own_router_id,
    input  logic               queue_full,
    output logic               push,
    output bmrc_pkg::msg_rec_t push_rec
);
    import bmrc_pkg::*;

    logic [12:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic        mbad_reg, mbad_next;
    logic [7:0]  ver_reg, ver_next;
    logic [15:0] as_reg, as_next;
    logic [15:0] hold_reg, hold_next;
    logic [31:0] id_reg, id_next;
    logic [7:0]  opt_reg, opt_next;
    logic [7:0]  fob_reg, fob_next;
    logic [15:0] wd_reg, wd_next;
    logic [15:0] attr_reg, attr_next;
    logic [31:0] arg_reg, arg_next;
    logic        drop_reg, drop_next;

    logic        accept;
    logic        hdr_err;
    logic        msg_end;
    logic        stop;
    logic [16:0] attr_hi_pos;
    logic [17:0] upd_sum;
    logic [16:0] wd_sum;
    msg_rec_t    rec;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;
    assign attr_hi_pos = 17'd21 + {1'b0, wd_reg};

    // Capture fields by byte position
    always_comb
    begin
        len_next  = len_reg;
        type_next = type_reg;
        mbad_next = mbad_reg;
        ver_next  = ver_reg;
        as_next   = as_reg;
        hold_next = hold_reg;
        id_next   = id_reg;
        opt_next  = opt_reg;
        fob_next  = fob_reg;
        wd_next   = wd_reg;
        attr_next = attr_reg;
        arg_next  = arg_reg;
        if (pos_reg < 13'd16)
        begin
            if (rx_byte != 8'hff)
                mbad_next = 1'b1;
        end
        else if (pos_reg == 13'd16)
            len_next = {rx_byte, 8'd0};
        else if (pos_reg == 13'd17)
            len_next = {len_reg[15:8], rx_byte};
        else if (pos_reg == 13'd18)
            type_next = rx_byte;
        else
        begin
            if (pos_reg == 13'd19)
            begin
                ver_next = rx_byte;
                wd_next  = {rx_byte, 8'd0};
            end
            if (pos_reg == 13'd20)
            begin
                as_next = {rx_byte, 8'd0};
                wd_next = {wd_reg[15:8], rx_byte};
            end
            if (pos_reg == 13'd21)
                as_next = {as_reg[15:8], rx_byte};
            if (pos_reg == 13'd22)
                hold_next = {rx_byte, 8'd0};
            if (pos_reg == 13'd23)
                hold_next = {hold_reg[15:8], rx_byte};
            if (pos_reg >= 13'd24 && pos_reg <= 13'd27)
                id_next = {id_reg[23:0], rx_byte};
            if (pos_reg == 13'd28)
                opt_next = rx_byte;
            if (pos_reg == 13'd29)
                fob_next = rx_byte;
            if (pos_reg >= 13'd21 && pos_reg <= 13'd24)
                arg_next = {arg_reg[23:0], rx_byte};
            if (pos_reg >= 13'd21)
            begin
                if ({4'd0, pos_reg} == attr_hi_pos)
                    attr_next = {rx_byte, 8'd0};
                if ({4'd0, pos_reg} == attr_hi_pos + 17'd1)
                    attr_next = {attr_reg[15:8], rx_byte};
            end
        end
    end

    assign hdr_err = (pos_reg == 13'd18) &&
                     (mbad_reg || len_reg < 16'(HeaderBytes) ||
                      len_reg > 16'(MaxMessageBytes));
    assign msg_end = (pos_reg >= 13'd18) &&
                     ({3'd0, pos_reg} + 16'd1 == len_next);

    assign wd_sum  = {1'b0, wd_next} + 17'd23;
    assign upd_sum = {1'b0, wd_sum} + {2'b0, attr_next};

    // Classify the finished message
    always_comb
    begin
        rec            = '0;
        rec.msg_type   = type_next;
        rec.msg_length = len_next[12:0];
        rec.kind       = EV_ERROR;
        stop           = 1'b1;
        if (pos_reg == 13'd18 && mbad_reg)
        begin
            rec.code    = ERR_HEADER;
            rec.subcode = SUB_MARKER;
        end
        else if (hdr_err)
        begin
            rec.code    = ERR_HEADER;
            rec.subcode = SUB_LENGTH;
            rec.detail  = {16'd0, len_next};
        end
        else
        begin
            case (type_next)
                TYPE_OPEN:
                begin
                    if (len_next < 16'd29 || len_next != 16'd29 + {8'd0, opt_next})
                    begin
                        rec.code = ERR_HEADER; rec.subcode = SUB_LENGTH;
                        rec.detail = {16'd0, len_next};
                    end
                    else if (ver_next != 8'd4)
                    begin
                        rec.code = ERR_OPEN; rec.subcode = SUB_VERSION;
                        rec.detail = {24'd0, ver_next};
                    end
                    else if (expected_peer_as != 16'd0 && as_next != expected_peer_as)
                    begin
                        rec.code = ERR_OPEN; rec.subcode = SUB_PEER_AS;
                        rec.detail = {16'd0, as_next};
                    end
                    else if (hold_next == 16'd1 || hold_next == 16'd2)
                    begin
                        rec.code = ERR_OPEN; rec.subcode = SUB_HOLD;
                        rec.detail = {16'd0, hold_next};
                    end
                    else if (opt_next != 8'd0)
                    begin
                        rec.code = ERR_OPEN; rec.subcode = SUB_OPT_PARAM;
                        rec.detail = {24'd0, fob_next};
                    end
                    else if (id_next == 32'd0 || id_next == 32'hffff_ffff ||
                             id_next == own_router_id)
                    begin
                        rec.code = ERR_OPEN; rec.subcode = SUB_ROUTER_ID;
                        rec.detail = id_next;
                    end
                    else
                    begin
                        rec.kind      = EV_OPEN;
                        rec.peer_as   = as_next;
                        rec.peer_id   = id_next;
                        rec.peer_hold = hold_next;
                        stop          = 1'b0;
                    end
                end
                TYPE_UPDATE:
                begin
                    if (len_next < 16'd23)
                    begin
                        rec.code = ERR_HEADER; rec.subcode = SUB_LENGTH;
                        rec.detail = {16'd0, len_next};
                    end
                    else if (wd_sum > {1'b0, len_next} || upd_sum > {2'b0, len_next} ||
                             (attr_next == 16'd0 && upd_sum != {2'b0, len_next}))
                    begin
                        rec.code = ERR_UPDATE; rec.subcode = SUB_ATTR_LIST;
                        rec.detail = {16'd0, len_next};
                    end
                    else
                    begin
                        rec.kind = EV_UPDATE;
                        stop     = 1'b0;
                    end
                end
                TYPE_NOTIFY:
                begin
                    if (len_next < 16'd21)
                    begin
                        rec.code = ERR_HEADER; rec.subcode = SUB_LENGTH;
                        rec.detail = {16'd0, len_next};
                    end
                    else
                    begin
                        rec.kind    = EV_NOTIFY;
                        rec.code    = ver_next;
                        rec.subcode = as_next[15:8];
                        if (len_next == 16'd22 || len_next == 16'd23 || len_next == 16'd25)
                            rec.detail = arg_next;
                    end
                end
                TYPE_KEEP:
                begin
                    if (len_next != 16'(HeaderBytes))
                    begin
                        rec.code = ERR_HEADER; rec.subcode = SUB_LENGTH;
                        rec.detail = {16'd0, len_next};
                    end
                    else
                    begin
                        rec.kind = EV_KEEP;
                        stop     = 1'b0;
                    end
                end
                default:
                begin
                    rec.code    = ERR_HEADER;
                    rec.subcode = SUB_TYPE;
                    rec.detail  = {24'd0, type_next};
                end
            endcase
        end
    end

    assign push     = accept && !drop_reg && (hdr_err || msg_end);
    assign push_rec = rec;

    // Advance position, clear captures at message end, latch drop
    always_comb
    begin
        pos_next  = pos_reg;
        drop_next = drop_reg;
        if (accept && !drop_reg)
        begin
            if (hdr_err || msg_end)
            begin
                pos_next = '0;
                if (hdr_err || stop)
                    drop_next = 1'b1;
            end
            else
                pos_next = pos_reg + 13'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0; len_reg  <= '0; type_reg <= '0; mbad_reg <= 1'b0;
            ver_reg  <= '0; as_reg   <= '0; hold_reg <= '0; id_reg   <= '0;
            opt_reg  <= '0; fob_reg  <= '0; wd_reg   <= '0; attr_reg <= '0;
            arg_reg  <= '0; drop_reg <= 1'b0;
        end
        else if (accept && !drop_reg)
        begin
            pos_reg  <= pos_next;
            drop_reg <= drop_next;
            if (hdr_err || msg_end)
            begin
                len_reg  <= '0; type_reg <= '0; mbad_reg <= 1'b0;
                ver_reg  <= '0; as_reg   <= '0; hold_reg <= '0; id_reg   <= '0;
                opt_reg  <= '0; fob_reg  <= '0; wd_reg   <= '0; attr_reg <= '0;
                arg_reg  <= '0;
            end
            else
            begin
                len_reg  <= len_next;  type_reg <= type_next; mbad_reg <= mbad_next;
                ver_reg  <= ver_next;  as_reg   <= as_next;   hold_reg <= hold_next;
                id_reg   <= id_next;   opt_reg  <= opt_next;  fob_reg  <= fob_next;
                wd_reg   <= wd_next;   attr_reg <= attr_next; arg_reg  <= arg_next;
            end
        end
    end

endmodule

// ===== rtl/bmrc_queue.sv =====
// Two-entry record queue between front and back ends.
// Depends on bmrc_pkg for the record type and depth.
module bmrc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bmrc_pkg::msg_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output bmrc_pkg::msg_rec_t pop_rec
);
    import bmrc_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    msg_rec_t        mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [PtrW:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (PtrW+1)'(QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign pop_rec   = mem_reg[rd_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed record
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_rec;
    end

endmodule

// ===== rtl/bmrc_back.sv =====
// Back end: turns queued records into result items, working out the
// agreed hold and keepalive times for OPEN. Depends on bmrc_pkg.
module bmrc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_avail,
    input  bmrc_pkg::msg_rec_t rec,
    output logic               pop,
    input  logic [15:0]        own_hold_time,
    input  logic [15:0]        own_keepalive_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_kind,
    output logic [7:0]         message_type,
    output logic [12:0]        message_length,
    output logic [7:0]         code_value,
    output logic [7:0]         subcode_value,
    output logic [31:0]        detail_data,
    output logic [15:0]        peer_as_number,
    output logic [31:0]        peer_router_id,
    output logic [15:0]        agreed_hold,
    output logic [15:0]        agreed_keepalive
);
    import bmrc_pkg::*;

    logic        valid_reg, valid_next;
    logic [2:0]  kind_reg;
    logic [7:0]  type_reg;
    logic [12:0] len_reg;
    logic [7:0]  code_reg, sub_reg;
    logic [31:0] detail_reg;
    logic [15:0] as_reg;
    logic [31:0] id_reg;
    logic [15:0] hold_reg, ka_reg;

    logic [15:0] agreed;
    logic [32:0] prod;
    logic [15:0] ka;
    logic        is_open;

    assign pop = rec_avail && (!valid_reg || !out_stall);

    // Agreed hold and keepalive
    always_comb
    begin
        is_open = (rec.kind == EV_OPEN);
        agreed  = (rec.peer_hold < own_hold_time) ? rec.peer_hold : own_hold_time;
        prod    = {17'd0, agreed} * {16'd0, DivThreeMul};
        ka      = (own_keepalive_time != 16'd0) ? own_keepalive_time
                                                : prod[DivThreeShift +: 16];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= rec.kind;
            type_reg   <= rec.msg_type;
            len_reg    <= rec.msg_length;
            code_reg   <= rec.code;
            sub_reg    <= rec.subcode;
            detail_reg <= rec.detail;
            as_reg     <= is_open ? rec.peer_as : 16'd0;
            id_reg     <= is_open ? rec.peer_id : 32'd0;
            hold_reg   <= is_open ? agreed : 16'd0;
            ka_reg     <= is_open ? ka : 16'd0;
        end
    end

    assign out_valid        = valid_reg;
    assign event_kind       = kind_reg;
    assign message_type     = type_reg;
    assign message_length   = len_reg;
    assign code_value       = code_reg;
    assign subcode_value    = sub_reg;
    assign detail_data      = detail_reg;
    assign peer_as_number   = as_reg;
    assign peer_router_id   = id_reg;
    assign agreed_hold      = hold_reg;
    assign agreed_keepalive = ka_reg;

endmodule

// ===== bench/tb.sv =====
// Testbench for bgp_message_receive_checker: byte stream stimulus, result scoreboard.
// Holds its own byte-level predictor of header, OPEN, UPDATE and NOTIFICATION checks.
// Depends on bmrc_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
    import bmrc_pkg::*;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  mtype;
        logic [12:0] mlen;
        logic [7:0]  code;
        logic [7:0]  sub;
        logic [31:0] detail;
        logic [15:0] peer_as;
        logic [31:0] peer_id;
        logic [15:0] hold;
        logic [15:0] keepalive;
    } bgp_result_t;

    localparam int IdleLimit = 5000;

    // Register index past the end of the list; writes to it are ignored
    localparam logic [2:0] CFG_UNUSED = 3'd5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_kind;
    logic [7:0]  message_type;
    logic [12:0] message_length;
    logic [7:0]  code_value;
    logic [7:0]  subcode_value;
    logic [31:0] detail_data;
    logic [15:0] peer_as_number;
    logic [31:0] peer_router_id;
    logic [15:0] agreed_hold;
    logic [15:0] agreed_keepalive;

    bgp_message_receive_checker u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_kind(event_kind), .message_type(message_type),
        .message_length(message_length), .code_value(code_value),
        .subcode_value(subcode_value), .detail_data(detail_data),
        .peer_as_number(peer_as_number), .peer_router_id(peer_router_id),
        .agreed_hold(agreed_hold), .agreed_keepalive(agreed_keepalive)
    );

    always #5 clk = ~clk;

    // Expected results and bookkeeping
    bgp_result_t expected_results[$];
    int          error_count = 0;
    int          bytes_sent = 0;
    bit          no_idle = 1'b0;
    int          stall_burst = 0;
    int          idle_cycles = 0;

    // Predictor copy of configuration
    logic [15:0] exp_peer_as;
    logic [31:0] own_id;
    logic [15:0] own_hold;
    logic [15:0] own_keep;

    // Predictor copy of per-message capture state
    int unsigned pos, len_f, wd_len, attr_f;
    logic [7:0]  type_f, ver_f, opt_len, first_opt;
    logic [15:0] as_f, hold_f;
    logic [31:0] id_f, arg_f;
    bit          marker_bad, dropping;

    // Packet under construction
    logic [7:0] pkt[$];
    int         pkt_len;

    function automatic bgp_result_t make_result(event_kind_t k, logic [7:0] c, logic [7:0] s,
                                                logic [31:0] d);
        bgp_result_t r;
        r = '0;
        r.kind = k;
        r.mtype = type_f;
        r.mlen = len_f[12:0];
        r.code = c;
        r.sub = s;
        r.detail = d;
        return r;
    endfunction

    task automatic clear_capture();
        pos = 0; len_f = 0; type_f = 0; marker_bad = 0; ver_f = 0; as_f = 0;
        hold_f = 0; id_f = 0; opt_len = 0; first_opt = 0; wd_len = 0;
        attr_f = 0; arg_f = 0;
    endtask

    // Classify a finished message; stop marks the end of the stream
    task automatic close_message(output bgp_result_t r, output bit stop);
        logic [15:0] agreed;
        int unsigned nlri;
        stop = 1;
        case (type_f)
            TYPE_OPEN: begin
                if (len_f < 29 || len_f != 29 + opt_len)
                    r = make_result(EV_ERROR, ERR_HEADER, SUB_LENGTH, len_f);
                else if (ver_f != 8'd4)
                    r = make_result(EV_ERROR, ERR_OPEN, SUB_VERSION, ver_f);
                else if (exp_peer_as != 0 && as_f != exp_peer_as)
                    r = make_result(EV_ERROR, ERR_OPEN, SUB_PEER_AS, as_f);
                else if (hold_f > 0 && hold_f < 3)
                    r = make_result(EV_ERROR, ERR_OPEN, SUB_HOLD, hold_f);
                else if (opt_len != 0)
                    r = make_result(EV_ERROR, ERR_OPEN, SUB_OPT_PARAM, first_opt);
                else if (id_f == 0 || id_f == 32'hffffffff || id_f == own_id)
                    r = make_result(EV_ERROR, ERR_OPEN, SUB_ROUTER_ID, id_f);
                else begin
                    agreed = (hold_f < own_hold) ? hold_f : own_hold;
                    r = make_result(EV_OPEN, 0, 0, 0);
                    r.peer_as = as_f;
                    r.peer_id = id_f;
                    r.hold = agreed;
                    r.keepalive = (own_keep != 0) ? own_keep : agreed / 16'd3;
                    stop = 0;
                end
            end
            TYPE_UPDATE: begin
                if (len_f < 23)
                    r = make_result(EV_ERROR, ERR_HEADER, SUB_LENGTH, len_f);
                else if (wd_len + attr_f + 23 > len_f)
                    r = make_result(EV_ERROR, ERR_UPDATE, SUB_ATTR_LIST, len_f);
                else begin
                    nlri = len_f - wd_len - attr_f - 23;
                    if (attr_f == 0 && nlri != 0)
                        r = make_result(EV_ERROR, ERR_UPDATE, SUB_ATTR_LIST, len_f);
                    else begin
                        r = make_result(EV_UPDATE, 0, 0, 0);
                        stop = 0;
                    end
                end
            end
            TYPE_NOTIFY: begin
                if (len_f < 21)
                    r = make_result(EV_ERROR, ERR_HEADER, SUB_LENGTH, len_f);
                else
                    r = make_result(EV_NOTIFY, ver_f, as_f[15:8],
                        (len_f == 22 || len_f == 23 || len_f == 25) ? arg_f : 32'd0);
            end
            TYPE_KEEP: begin
                if (len_f != HeaderBytes)
                    r = make_result(EV_ERROR, ERR_HEADER, SUB_LENGTH, len_f);
                else begin
                    r = make_result(EV_KEEP, 0, 0, 0);
                    stop = 0;
                end
            end
            default: r = make_result(EV_ERROR, ERR_HEADER, SUB_TYPE, type_f);
        endcase
    endtask

    // Advance the predictor by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        int unsigned p;
        bgp_result_t r;
        bit done, stop;
        p = pos;
        done = 0;
        stop = 0;
        if (dropping)
            return;
        if (p < 16) begin
            if (b != 8'hff)
                marker_bad = 1;
        end else if (p == 16) begin
            len_f = {b, 8'h00};
        end else if (p == 17) begin
            len_f = len_f | b;
        end else if (p == 18) begin
            type_f = b;
            if (marker_bad) begin
                r = make_result(EV_ERROR, ERR_HEADER, SUB_MARKER, 0);
                done = 1; stop = 1;
            end else if (len_f < HeaderBytes || len_f > MaxMessageBytes) begin
                r = make_result(EV_ERROR, ERR_HEADER, SUB_LENGTH, len_f);
                done = 1; stop = 1;
            end
        end else begin
            if (p == 19) begin ver_f = b; wd_len = {b, 8'h00}; end
            if (p == 20) begin as_f = {b, 8'h00}; wd_len = wd_len | b; end
            if (p == 21) as_f[7:0] = b;
            if (p == 22) hold_f = {b, 8'h00};
            if (p == 23) hold_f[7:0] = b;
            if (p >= 24 && p <= 27) id_f = {id_f[23:0], b};
            if (p == 28) opt_len = b;
            if (p == 29) first_opt = b;
            if (p >= 21 && p <= 24) arg_f = {arg_f[23:0], b};
            if (p >= 21) begin
                if (p == 21 + wd_len) attr_f = {b, 8'h00};
                if (p == 22 + wd_len) attr_f = attr_f | b;
            end
        end
        if (!done && p >= 18 && p + 1 == len_f) begin
            close_message(r, stop);
            done = 1;
        end
        if (done) begin
            expected_results.push_back(r);
            clear_capture();
            if (stop)
                dropping = 1;
        end else begin
            pos = (p + 1) & 32'h1fff;
        end
    endtask

    // Send one item, with a random gap, possibly none, in front of it
    task automatic send_byte(input logic [7:0] b);
        int gap, r;
        r = $urandom_range(0, 99);
        gap = (no_idle || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        track_byte(b);
        bytes_sent++;
    endtask

    // Wait until every expected result has come, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_PEER_AS:   exp_peer_as = val[15:0];
            CFG_ROUTER_ID: own_id = val;
            CFG_HOLD:      own_hold = val[15:0];
            CFG_KEEPALIVE: own_keep = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] as_v, input logic [31:0] id_v,
                             input logic [15:0] hold_v, input logic [15:0] keep_v);
        drain();
        write_reg(CFG_PEER_AS, {16'd0, as_v});
        write_reg(CFG_ROUTER_ID, id_v);
        write_reg(CFG_HOLD, {16'd0, hold_v});
        write_reg(CFG_KEEPALIVE, {16'd0, keep_v});
    endtask

    // Packet building
    task automatic begin_pkt(input int len, input logic [7:0] t, input bit bad_marker);
        int k;
        pkt.delete();
        k = $urandom_range(0, 15);
        for (int i = 0; i < 16; i++)
            pkt.push_back((bad_marker && i == k) ? 8'($urandom_range(0, 254)) : 8'hff);
        pkt.push_back(len[15:8]);
        pkt.push_back(len[7:0]);
        pkt.push_back(t);
        pkt_len = len;
    endtask

    task automatic put16(input logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    // Pad with random content and send; a bad header length ends at the type byte
    task automatic send_pkt();
        int n;
        n = (pkt_len < HeaderBytes || pkt_len > MaxMessageBytes) ? HeaderBytes : pkt_len;
        while (pkt.size() < n)
            pkt.push_back(8'($urandom));
        for (int i = 0; i < n; i++)
            send_byte(pkt[i]);
    endtask

    task automatic send_open(input int len, input logic [7:0] ver, input logic [15:0] as_v,
                             input logic [15:0] hold_v, input logic [31:0] id_v,
                             input logic [7:0] opt);
        begin_pkt(len, TYPE_OPEN, 0);
        pkt.push_back(ver);
        put16(as_v);
        put16(hold_v);
        put32(id_v);
        pkt.push_back(opt);
        send_pkt();
    endtask

    task automatic send_update(input int wd, input int attr, input int nlri);
        begin_pkt(23 + wd + attr + nlri, TYPE_UPDATE, 0);
        put16(16'(wd));
        repeat (wd) pkt.push_back(8'($urandom));
        put16(16'(attr));
        send_pkt();
    endtask

    task automatic send_keepalive();
        begin_pkt(HeaderBytes, TYPE_KEEP, 0);
        send_pkt();
    endtask

    // An OPEN that passes every check under the current settings
    task automatic send_good_open();
        logic [15:0] as_v, hold_v;
        logic [31:0] id_v;
        as_v = (exp_peer_as != 0) ? exp_peer_as : 16'($urandom);
        hold_v = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(3, 65535));
        do id_v = $urandom; while (id_v == 0 || id_v == 32'hffffffff || id_v == own_id);
        send_open(29, 8'd4, as_v, hold_v, id_v, 8'd0);
    endtask

    task automatic send_good_update();
        int wd, attr;
        wd = $urandom_range(0, 12);
        attr = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        send_update(wd, attr, (attr == 0) ? 0 : $urandom_range(0, 16));
    endtask

    // Tests
    task automatic test_reset_values();
        no_idle = 1'b1;
        send_open(29, 8'd4, 16'd100, 16'd300, 32'h0a000001, 8'd0);
        send_keepalive();
        no_idle = 1'b0;
    endtask

    task automatic test_open_limits();
        write_all(16'hffff, 32'hffff_fffe, 16'd0, 16'hffff);
        write_reg(CFG_UNUSED, $urandom);
        send_open(29, 8'd4, 16'hffff, 16'hffff, 32'h0000_0001, 8'd0);
        write_all(16'd0, 32'h1234_5678, 16'hffff, 16'd0);
        send_open(29, 8'd4, 16'd0, 16'd0, 32'hffff_fffe, 8'd0);
        send_open(29, 8'd4, 16'd1, 16'd3, 32'h1234_5679, 8'd0);
        send_open(29, 8'd4, 16'd2, 16'hffff, 32'h8000_0000, 8'd0);
    endtask

    task automatic test_update_sections();
        send_update(0, 0, 0);
        send_update(3, 5, 4);
        send_update(0, 1, 0);
        send_update(7, 0, 0);
    endtask

    task automatic test_random_traffic();
        int next_cfg;
        next_cfg = bytes_sent + 250;
        while (bytes_sent < 1750) begin
            case ($urandom_range(0, 2))
                0: send_good_open();
                1: send_good_update();
                default: send_keepalive();
            endcase
            if (bytes_sent >= next_cfg) begin
                next_cfg = bytes_sent + 250;
                no_idle = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 2))
                    0: write_all(16'($urandom), $urandom, 16'($urandom), 16'($urandom));
                    1: write_all(16'd0, 32'd0, 16'hffff, 16'd0);
                    default: write_all(16'd0, $urandom, 16'($urandom_range(0, 10)),
                                       ($urandom_range(0, 1) != 0) ? 16'd0 : 16'hffff);
                endcase
            end else if ($urandom_range(0, 9) == 0) begin
                drain();
            end
        end
        no_idle = 1'b0;
    endtask

    // One message that ends the stream, then bytes that must be dropped
    task automatic test_stream_end();
        logic [7:0] t;
        int len;
        case ($urandom_range(0, 16))
            0: begin begin_pkt($urandom_range(19, 40), TYPE_KEEP, 1); send_pkt(); end
            1: begin begin_pkt($urandom_range(0, 18), TYPE_OPEN, 0); send_pkt(); end
            2: begin begin_pkt($urandom_range(4097, 65535), TYPE_UPDATE, 0); send_pkt(); end
            3: begin
                do t = $urandom; while (t >= TYPE_OPEN && t <= TYPE_KEEP);
                len = $urandom_range(19, 60);
                begin_pkt(len, t, 0);
                send_pkt();
            end
            4: send_open($urandom_range(19, 28), 8'd4, 16'd1, 16'd90, 32'd7, 8'd0);
            5: send_open(30 + $urandom_range(0, 5), 8'd4, 16'd1, 16'd90, 32'd7, 8'd0);
            6: send_open(29, 8'($urandom_range(5, 255)), 16'd1, 16'd90, 32'd7, 8'd0);
            7: begin
                write_all(16'($urandom_range(1, 65535)), 32'd0, 16'd240, 16'd0);
                send_open(29, 8'd4, 16'($urandom), 16'd90, 32'd7, 8'd0);
            end
            8: send_open(29, 8'd4, 16'd1, 16'($urandom_range(1, 2)), 32'd7, 8'd0);
            9: begin
                len = $urandom_range(1, 20);
                send_open(29 + len, 8'd4, 16'd1, 16'd90, 32'd7, 8'(len));
            end
            10: send_open(29, 8'd4, 16'd1, 16'd90,
                          ($urandom_range(0, 2) == 0) ? 32'd0 :
                          ($urandom_range(0, 1) != 0) ? 32'hffffffff : own_id, 8'd0);
            11: begin begin_pkt($urandom_range(19, 22), TYPE_UPDATE, 0); send_pkt(); end
            12: begin
                begin_pkt(30, TYPE_UPDATE, 0);
                put16(16'($urandom_range(0, 20)));
                put16(16'($urandom_range(8, 40)));
                send_pkt();
            end
            13: send_update(2, 0, $urandom_range(1, 9));
            14: begin begin_pkt($urandom_range(19, 20), TYPE_NOTIFY, 0); send_pkt(); end
            15: begin begin_pkt($urandom_range(21, 26), TYPE_NOTIFY, 0); send_pkt(); end
            default: begin begin_pkt($urandom_range(20, 40), TYPE_KEEP, 0); send_pkt(); end
        endcase
        repeat (40) send_byte(8'($urandom));
        in_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Check each accepted result and drive random output stalls
    always @(posedge clk) begin
        bgp_result_t e;
        if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d type %0d", event_kind,
                       message_type);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("event_kind", e.kind, event_kind);
                check_field("message_type", e.mtype, message_type);
                check_field("message_length", e.mlen, message_length);
                check_field("code_value", e.code, code_value);
                check_field("subcode_value", e.sub, subcode_value);
                check_field("detail_data", e.detail, detail_data);
                check_field("peer_as_number", e.peer_as, peer_as_number);
                check_field("peer_router_id", e.peer_id, peer_router_id);
                check_field("agreed_hold", e.hold, agreed_hold);
                check_field("agreed_keepalive", e.keepalive, agreed_keepalive);
            end
        end
        if (stall_burst > 0) begin
            stall_burst--;
            out_stall <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 199) == 0) begin
            stall_burst = $urandom_range(10, 50);
            out_stall <= 1'b1;
        end else begin
            out_stall <= !no_idle && ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        exp_peer_as = 0;
        own_id = 0;
        own_hold = 16'd240;
        own_keep = 0;
        dropping = 0;
        clear_capture();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_open_limits();
        test_update_sections();
        test_random_traffic();
        test_stream_end();

        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
